>>> rtl/c2pd_pkg.sv
// Shared types, constants and helper functions for the cartesian to polar block.
// No dependencies; imported by the top level, by its checker and by the testbench.
package c2pd_pkg;

   // default number of CORDIC rotations
   localparam int CORDIC_STEPS_DEFAULT = 18;

   // one root bit per square root stage: 18-bit root of a 36-bit radicand
   localparam int SQRT_STEPS = 18;

   // datapath widths
   localparam int RAD_W  = 36;   // 16 * (x*x + y*y)
   localparam int CW     = 35;   // signed CORDIC x and y
   localparam int ZW     = 29;   // signed angle accumulator, 2^-20 degree
   localparam int ATAN_W = 28;   // arctangent table entries
   localparam int FOLD_W = 14;   // first-quadrant angle, 1/128 degree
   localparam int ANG_W  = 17;   // angle before wrap

   // angle accumulator scaling
   localparam int ANG_SHIFT = 13;
   localparam logic [26:0] DEG90_FINE = 27'd94371840;

   // angle codes in 1/128 degree
   localparam logic [ANG_W-1:0] ANG_0   = 17'd0;
   localparam logic [ANG_W-1:0] ANG_90  = 17'd11520;
   localparam logic [ANG_W-1:0] ANG_180 = 17'd23040;
   localparam logic [ANG_W-1:0] ANG_270 = 17'd34560;
   localparam logic [ANG_W-1:0] ANG_360 = 17'd46080;

   // largest magnitude that can come out
   localparam logic [17:0] MAG_MAX = 18'd185364;

   // input word
   typedef struct packed {
      logic signed [15:0] vec_x;
      logic signed [15:0] vec_y;
   } req_type;

   // result word
   typedef struct packed {
      logic [17:0] magnitude;
      logic [15:0] angle;
   } rsp_type;

   // sign and axis flags carried down the pipe
   typedef struct packed {
      logic x_zero;
      logic y_zero;
      logic x_neg;
      logic y_neg;
   } axis_type;

   // after the squaring stage
   typedef struct packed {
      logic [30:0] xx;
      logic [30:0] yy;
      logic [16:0] ax;
      logic [16:0] ay;
      axis_type    axis;
   } front_type;

   // one iteration stage: square root and CORDIC side by side
   typedef struct packed {
      logic [RAD_W-1:0]     rem;
      logic [RAD_W-1:0]     root;
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic signed [ZW-1:0] z;
      axis_type             axis;
   } iter_type;

   // after rounding
   typedef struct packed {
      logic [17:0]       mag;
      logic [FOLD_W-1:0] fold;
      axis_type          axis;
   } fin_type;

   // atan(2^-i) in degrees times 2^20, rounded
   function automatic logic [ATAN_W-1:0] atan_deg(input int unsigned idx);
      logic [ATAN_W-1:0] val;
      case (idx)
         0:  val = 28'd47185920;
         1:  val = 28'd27855475;
         2:  val = 28'd14718068;
         3:  val = 28'd7471121;
         4:  val = 28'd3750058;
         5:  val = 28'd1876857;
         6:  val = 28'd938658;
         7:  val = 28'd469357;
         8:  val = 28'd234682;
         9:  val = 28'd117342;
         10: val = 28'd58671;
         11: val = 28'd29335;
         12: val = 28'd14668;
         13: val = 28'd7334;
         14: val = 28'd3667;
         15: val = 28'd1833;
         16: val = 28'd917;
         17: val = 28'd458;
         18: val = 28'd229;
         19: val = 28'd115;
         20: val = 28'd57;
         21: val = 28'd29;
         22: val = 28'd14;
         23: val = 28'd7;
         24: val = 28'd4;
         25: val = 28'd2;
         26: val = 28'd1;
         default: val = 28'd0;
      endcase
      return val;
   endfunction

   // iteration stages: the longer of the two recurrences
   function automatic int c2pd_stages(input int steps);
      return (steps > SQRT_STEPS) ? steps : SQRT_STEPS;
   endfunction

   // edges from accepting a word to sampling its result strobe
   function automatic int c2pd_latency(input int steps);
      return c2pd_stages(steps) + 4;
   endfunction

endpackage

>>> rtl/cartesian_to_polar_degrees.sv
// Pipelined cartesian to polar converter: magnitude times 4 and angle in 1/128 degree.
// Depends on c2pd_pkg (word types, arctangent table, stage count).
//
//   channel   ports                       direction  handshake
//   request   start, busy, req_word       in         taken when start && !busy
//   response  rsp_strobe, rsp_word        out        one-cycle strobe, no backpressure
//
// One word enters per cycle; each word passes the front, seed, iteration, rounding and output
// registers before its result strobe rises. The depth is set by the iteration pipe, at most one CORDIC
// rotation and one square-root bit per stage.
// Reset is synchronous and clears only the valid bits; busy follows reset, words in
// flight at reset are dropped. Nothing ever stalls: busy is low whenever out of reset.
module cartesian_to_polar_degrees import c2pd_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   localparam int NSTAGE = c2pd_stages(CORDIC_STEPS);

   logic      accept;
   front_type front_in, front_ff;
   logic      front_vld_ff;
   logic signed [31:0] sq_x, sq_y;
   logic signed [16:0] x_ext, y_ext;

   iter_type  seed_in;
   iter_type  iter_in  [0:NSTAGE-1];
   iter_type  iter_ff  [0:NSTAGE];
   logic      iter_vld_ff [0:NSTAGE];

   fin_type   fin_in, fin_ff;
   logic      fin_vld_ff;

   rsp_type   rsp_in, rsp_word_ff;
   logic      rsp_strobe_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   // front: squares, absolute values and axis flags
   always_comb begin
      sq_x  = req_word.vec_x * req_word.vec_x;
      sq_y  = req_word.vec_y * req_word.vec_y;
      x_ext = {req_word.vec_x[15], req_word.vec_x};
      y_ext = {req_word.vec_y[15], req_word.vec_y};
      front_in.xx = sq_x[30:0];
      front_in.yy = sq_y[30:0];
      front_in.axis.x_zero = (req_word.vec_x == 16'sd0);
      front_in.axis.y_zero = (req_word.vec_y == 16'sd0);
      front_in.axis.x_neg  = req_word.vec_x[15];
      front_in.axis.y_neg  = req_word.vec_y[15];
      front_in.ax = req_word.vec_x[15] ? -x_ext : x_ext;
      front_in.ay = req_word.vec_y[15] ? -y_ext : y_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= 1'b0;
      end else begin
         front_vld_ff <= accept;
      end
      front_ff <= front_in;
   end

   // seed: radicand and CORDIC start vector
   always_comb begin
      seed_in.rem  = {({1'b0, front_ff.xx} + {1'b0, front_ff.yy}), 4'b0000};
      seed_in.root = '0;
      seed_in.cx   = {2'b00, front_ff.ax, 16'h0000};
      seed_in.cy   = {2'b00, front_ff.ay, 16'h0000};
      seed_in.z    = '0;
      seed_in.axis = front_ff.axis;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_vld_ff[0] <= 1'b0;
      end else begin
         iter_vld_ff[0] <= front_vld_ff;
      end
      iter_ff[0] <= seed_in;
   end

   // iteration pipe: at most one rotation and one root bit per stage
   for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
      localparam int SQ_EXP = (k < SQRT_STEPS) ? 2 * (SQRT_STEPS - 1 - k) : 0;
      localparam logic [RAD_W-1:0] SQ_BIT = RAD_W'(1) << SQ_EXP;
      localparam logic signed [ZW-1:0] ATAN_K = signed'({1'b0, atan_deg(k)});

      always_comb begin : comb_step
         logic [RAD_W-1:0]     trial;
         logic signed [CW-1:0] dx;
         logic signed [CW-1:0] dy;
         iter_in[k] = iter_ff[k];
         trial = iter_ff[k].root + SQ_BIT;
         dx    = iter_ff[k].cy >>> k;
         dy    = iter_ff[k].cx >>> k;
         // vectoring rotation toward the x axis
         if (k < CORDIC_STEPS) begin
            if (iter_ff[k].cy > 0) begin
               iter_in[k].cx = iter_ff[k].cx + dx;
               iter_in[k].cy = iter_ff[k].cy - dy;
               iter_in[k].z  = iter_ff[k].z + ATAN_K;
            end else begin
               iter_in[k].cx = iter_ff[k].cx - dx;
               iter_in[k].cy = iter_ff[k].cy + dy;
               iter_in[k].z  = iter_ff[k].z - ATAN_K;
            end
         end
         // restoring square root bit
         if (k < SQRT_STEPS) begin
            if (iter_ff[k].rem >= trial) begin
               iter_in[k].rem  = iter_ff[k].rem - trial;
               iter_in[k].root = (iter_ff[k].root >> 1) + SQ_BIT;
            end else begin
               iter_in[k].root = iter_ff[k].root >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            iter_vld_ff[k+1] <= 1'b0;
         end else begin
            iter_vld_ff[k+1] <= iter_vld_ff[k];
         end
         iter_ff[k+1] <= iter_in[k];
      end
   end

   // rounding: clamp and round the folded angle, round the root half up
   always_comb begin : comb_round
      logic [26:0] zc;
      logic [27:0] zr;
      if (iter_ff[NSTAGE].z < 0) begin
         zc = '0;
      end else if (iter_ff[NSTAGE].z > signed'({2'b00, DEG90_FINE})) begin
         zc = DEG90_FINE;
      end else begin
         zc = iter_ff[NSTAGE].z[26:0];
      end
      zr = {1'b0, zc} + (28'd1 << (ANG_SHIFT - 1));
      fin_in.fold = zr[ANG_SHIFT+FOLD_W-1:ANG_SHIFT];
      fin_in.mag  = iter_ff[NSTAGE].root[17:0]
                  + {17'b0, (iter_ff[NSTAGE].rem > iter_ff[NSTAGE].root)};
      fin_in.axis = iter_ff[NSTAGE].axis;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
      end else begin
         fin_vld_ff <= iter_vld_ff[NSTAGE];
      end
      fin_ff <= fin_in;
   end

   // quadrant mapping, axis cases and full-turn wrap
   always_comb begin : comb_quad
      logic [ANG_W-1:0] fold17;
      logic [ANG_W-1:0] ang;
      fold17 = {{(ANG_W-FOLD_W){1'b0}}, fin_ff.fold};
      if (fin_ff.axis.x_zero) begin
         ang = fin_ff.axis.y_neg ? ANG_270 : ANG_90;
      end else if (fin_ff.axis.y_zero) begin
         ang = fin_ff.axis.x_neg ? ANG_180 : ANG_0;
      end else if (!fin_ff.axis.x_neg && !fin_ff.axis.y_neg) begin
         ang = fold17;
      end else if (fin_ff.axis.x_neg && !fin_ff.axis.y_neg) begin
         ang = ANG_180 - fold17;
      end else if (fin_ff.axis.x_neg) begin
         ang = ANG_180 + fold17;
      end else begin
         ang = ANG_360 - fold17;
      end
      if (ang >= ANG_360) begin
         ang = ang - ANG_360;
      end
      rsp_in.angle     = ang[15:0];
      rsp_in.magnitude = fin_ff.mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= fin_vld_ff;
      end
      rsp_word_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

>>> rtl/c2pd_checker.sv
// Port-level checks for the cartesian to polar converter, bound to its top level.
// Depends on c2pd_pkg (word types, latency, angle codes).
module c2pd_checker import c2pd_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_word,
   input logic    rsp_strobe,
   input rsp_type rsp_word
);

   localparam int LATENCY = c2pd_latency(CORDIC_STEPS);

   // every accepted word gives a result after the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted word produced no result");

   // no result without a word accepted that many cycles earlier
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result strobe without matching word");

   // results stay in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ({1'b0, rsp_word.angle} < ANG_360 && rsp_word.magnitude <= MAG_MAX))
      else $error("result out of range");

   // the origin gives zero length at 90 degrees
   a_origin: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.vec_x == 16'sd0 && req_word.vec_y == 16'sd0)
      |-> ##LATENCY (rsp_word.magnitude == 18'd0 && {1'b0, rsp_word.angle} == ANG_90))
      else $error("origin result wrong");

endmodule

bind cartesian_to_polar_degrees c2pd_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_c2pd_checker (.*);

>>> tb/cartesian_to_polar_degrees_tb.sv
// Self-checking testbench for the cartesian to polar converter: directed axis and corner
// words, then random vectors, each result checked against a bit-exact polar predictor.
// Depends on c2pd_pkg (word types, angle codes, latency) and the cartesian_to_polar_degrees RTL.
module cartesian_to_polar_degrees_tb;
   import c2pd_pkg::*;

   localparam int STEPS       = CORDIC_STEPS_DEFAULT;
   localparam int RANDOM_WORDS = 1900;
   localparam int DRAIN_CYCLES = 20000;

   // expected polar results, one per accepted vector, in order
   class polar_tracker;
      rsp_type polar_due[$];
      int      steps;
      int      n_noted;
      int      n_checked;
      int      n_errors;

      function new(int s);
         steps     = s;
         n_noted   = 0;
         n_checked = 0;
         n_errors  = 0;
      endfunction

      // integer square root, bit by bit
      function longint unsigned root_of(longint unsigned n);
         longint unsigned res   = 0;
         longint unsigned probe = 64'h1 << 62;
         while (probe > n)
            probe = probe >> 2;
         while (probe != 0) begin
            if (n >= res + probe) begin
               n   = n - (res + probe);
               res = (res >> 1) + probe;
            end else begin
               res = res >> 1;
            end
            probe = probe >> 2;
         end
         return res;
      endfunction

      // CORDIC vectoring on a first-quadrant vector, angle in 1/128 degree
      function longint quadrant_angle(longint ax, longint ay);
         longint atan_fine [32];
         longint cx;
         longint cy;
         longint z;
         longint dx;
         longint dy;
         atan_fine = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
                       469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
                       917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0};
         cx = ax <<< 16;
         cy = ay <<< 16;
         z  = 0;
         for (int i = 0; i < steps && i < 32; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0) begin
               cx = cx + dx;
               cy = cy - dy;
               z  = z + atan_fine[i];
            end else begin
               cx = cx - dx;
               cy = cy + dy;
               z  = z - atan_fine[i];
            end
         end
         // residue can push the sum just past either end of the quadrant
         if (z < 0)
            z = 0;
         if (z > longint'(DEG90_FINE))
            z = longint'(DEG90_FINE);
         return (z + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
      endfunction

      // magnitude times 4 and angle in 1/128 degree for one input word
      function rsp_type polar_of(req_type w);
         longint          x;
         longint          y;
         longint          q;
         longint          ang;
         longint unsigned n;
         longint unsigned r;
         rsp_type         res;
         x = longint'($signed(w.vec_x));
         y = longint'($signed(w.vec_y));
         n = 16 * longint'(x * x + y * y);
         r = root_of(n);
         if (n - r * r > r)
            r = r + 1;
         // exact axes bypass the rotation
         if (x == 0) begin
            ang = (y < 0) ? longint'(ANG_270) : longint'(ANG_90);
         end else if (y == 0) begin
            ang = (x < 0) ? longint'(ANG_180) : longint'(ANG_0);
         end else begin
            q = quadrant_angle(x < 0 ? -x : x, y < 0 ? -y : y);
            if (x > 0 && y > 0)
               ang = q;
            else if (x < 0 && y > 0)
               ang = longint'(ANG_180) - q;
            else if (x < 0)
               ang = longint'(ANG_180) + q;
            else
               ang = longint'(ANG_360) - q;
            // full turn wraps to zero
            if (ang >= longint'(ANG_360))
               ang = ang - longint'(ANG_360);
         end
         res.magnitude = r[17:0];
         res.angle     = ang[15:0];
         return res;
      endfunction

      function int pending();
         return polar_due.size();
      endfunction

      function void note(req_type w);
         polar_due = {polar_due, polar_of(w)};
         n_noted++;
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         n_errors++;
      endtask

      task check(rsp_type got);
         rsp_type want;
         if (polar_due.size() == 0) begin
            report($sformatf("result word mag %0d ang %0d with no vector waiting",
                             got.magnitude, got.angle));
         end else begin
            want = polar_due.pop_front();
            if (got.magnitude !== want.magnitude)
               report($sformatf("word %0d magnitude got %0d want %0d", n_checked,
                                got.magnitude, want.magnitude));
            if (got.angle !== want.angle)
               report($sformatf("word %0d angle got %0d want %0d", n_checked,
                                got.angle, want.angle));
         end
         n_checked++;
      endtask
   endclass

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_word = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_word;

   polar_tracker sb = new(STEPS);

   cartesian_to_polar_degrees #(.CORDIC_STEPS(STEPS)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always #2 clock = ~clock;

   // note every accepted vector
   always @(posedge clock) begin
      if (!reset && start && !busy)
         sb.note(req_word);
   end

   // check every strobed result
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check(rsp_word);
   end

   // hold one vector until the block takes it
   task automatic send_vec(input int vx, input int vy);
      req_type w;
      w.vec_x = 16'(vx);
      w.vec_y = 16'(vy);
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // start low with junk on the word lines
   task automatic idle_for(input int n);
      repeat (n) begin
         start    <= 1'b0;
         req_word <= req_type'($urandom);
         @(posedge clock);
      end
   endtask

   // one random vector, mixed over the interesting regions
   task automatic send_random();
      int pick;
      int a;
      int b;
      pick = $urandom_range(0, 9);
      a = int'($signed(16'($urandom)));
      b = int'($signed(16'($urandom)));
      case (pick)
         4, 5: begin
            a = $urandom_range(0, 16) - 8;
            b = $urandom_range(0, 16) - 8;
         end
         6: a = $urandom_range(0, 6) - 3;
         7: b = $urandom_range(0, 6) - 3;
         8: begin
            a = (a < 0) ? (a | 32'hffff_c000) : (a | 32'h0000_4000);
            b = (b < 0) ? (b | 32'hffff_c000) : (b | 32'h0000_4000);
         end
         9: begin
            if ($urandom_range(0, 1))
               a = 0;
            else
               b = 0;
         end
         default: ;
      endcase
      send_vec(a, b);
   endtask

   initial begin
      bit calm;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // corners, axes, origin and the wrap points
      send_vec(-32768, -32768);
      send_vec(32767, 32767);
      send_vec(-32768, 32767);
      send_vec(32767, -32768);
      send_vec(0, 0);
      send_vec(0, 1);
      send_vec(0, -1);
      send_vec(0, 32767);
      idle_for(2);
      send_vec(0, -32768);
      send_vec(1, 0);
      send_vec(-1, 0);
      send_vec(32767, 0);
      send_vec(-32768, 0);
      idle_for(1);
      send_vec(1, 1);
      send_vec(-1, 1);
      send_vec(-1, -1);
      send_vec(1, -1);
      send_vec(1, 32767);
      send_vec(-1, 32767);
      send_vec(32767, 1);
      send_vec(32767, -1);
      send_vec(-32768, -1);
      send_vec(-32768, 1);
      send_vec(-2, -32768);

      // random vectors with random gaps, one calm stretch, one full drain
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         calm = (k >= 400 && k < 700);
         if (k == 950) begin
            start <= 1'b0;
            while (sb.pending() != 0)
               @(posedge clock);
         end
         // a random gap of idle cycles before about 7 words in 100
         if (!calm && $urandom_range(0, 99) < 7)
            idle_for($urandom_range(1, 6));
         send_random();
      end
      start <= 1'b0;

      // let the pipe empty, then watch for strays
      for (int k = 0; k < DRAIN_CYCLES && sb.pending() != 0; k++)
         @(posedge clock);
      repeat (c2pd_latency(STEPS) + 4) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected results never came", sb.pending()));

      $display("run covered %0d vectors and %0d results: axes, origin, corners, wrap points,",
               sb.n_noted, sb.n_checked);
      $display("then full-range, small, near-axis and large random vectors with gaps");
      if (sb.n_errors == 0) begin
         $display("cartesian_to_polar_degrees_tb OK");
      end else begin
         $display("cartesian_to_polar_degrees_tb NOT OK");
      end
      $finish;
   end

   // hard stop if the run hangs
   initial begin
      #400000;
      $display("timeout");
      $display("cartesian_to_polar_degrees_tb NOT OK");
      $finish;
   end

endmodule
